// ----- hw/rtl/psfla_pkg.sv -----
// Package for the packet switch frame lock arbiter.
// Holds the fixed port geometry, field widths and the per-egress status word.
// No dependencies.
package psfla_pkg;

  // The ports on the top level are always sized for four ingress and egress ports.
  localparam int unsigned PortsMax = 4;
  // Width of a destination or select field.
  localparam int unsigned DestW    = 2;
  // Width of a wait count as it appears on the result word.
  localparam int unsigned OutCntW  = 32;

  // Status of one egress arbiter for the word being processed.
  typedef struct packed {
    logic             active;
    logic             lost;
    logic [DestW-1:0] sel;
  } egr_status_t;

endpackage

// ----- hw/rtl/psfla_egress_arb.sv -----
// One egress arbiter: frame lock, locked ingress and round-robin pointer.
// Depends on psfla_pkg.
module psfla_egress_arb import psfla_pkg::*; #(
  parameter int unsigned NUM_PORTS = 4,
  parameter int unsigned EGRESS_ID = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [PortsMax-1:0]            vld_i,
  input  logic [PortsMax-1:0]            lst_i,
  input  logic [PortsMax-1:0][DestW-1:0] dst_i,
  output logic [PortsMax-1:0]            grant_o,
  output egr_status_t                    status_o
);

  localparam int unsigned IdxW = $clog2(NUM_PORTS);

  logic            lock_q, lock_d;
  logic [IdxW-1:0] lidx_q, lidx_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [NUM_PORTS-1:0] req;

  // Advance an ingress index by one with wrap at the port count.
  function automatic logic [IdxW-1:0] next_port(logic [IdxW-1:0] p);
    logic [IdxW-1:0] r;
    if (p == IdxW'(NUM_PORTS - 1)) begin
      r = '0;
    end else begin
      r = p + IdxW'(1);
    end
    return r;
  endfunction

  // Requests addressed to this egress.
  always_comb begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      req[i] = vld_i[i] && (dst_i[i] == DestW'(EGRESS_ID));
    end
  end

  // Lock check, then a round-robin search if the lock did not grant.
  always_comb begin
    logic            done;
    logic            found;
    logic [IdxW-1:0] ptr_eff;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] pick;
    lock_d   = lock_q;
    lidx_d   = lidx_q;
    ptr_d    = ptr_q;
    grant_o  = '0;
    status_o = '0;
    done     = 1'b0;
    found    = 1'b0;
    ptr_eff  = ptr_q;
    idx      = ptr_q;
    pick     = '0;

    if (lock_q) begin
      if (req[lidx_q]) begin
        grant_o[lidx_q] = 1'b1;
        status_o.active = 1'b1;
        status_o.sel    = DestW'(lidx_q);
        done            = 1'b1;
        if (lst_i[lidx_q]) begin
          lock_d = 1'b0;
          ptr_d  = next_port(lidx_q);
        end
      end else begin
        // Locked ingress went away or changed destination.
        status_o.lost = 1'b1;
        lock_d        = 1'b0;
        ptr_d         = next_port(lidx_q);
        ptr_eff       = next_port(lidx_q);
      end
    end

    if (!done) begin
      idx = ptr_eff;
      for (int k = 0; k < NUM_PORTS; k++) begin
        if (!found && req[idx]) begin
          found = 1'b1;
          pick  = idx;
        end
        idx = next_port(idx);
      end
      if (found) begin
        grant_o[pick]   = 1'b1;
        status_o.active = 1'b1;
        status_o.sel    = DestW'(pick);
        if (lst_i[pick]) begin
          lock_d = 1'b0;
          ptr_d  = next_port(pick);
        end else begin
          lock_d = 1'b1;
          lidx_d = pick;
        end
      end
    end
  end

  // Arbiter state moves only when a word passes to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= 1'b0;
      lidx_q <= '0;
      ptr_q  <= '0;
    end else if (step_i) begin
      lock_q <= lock_d;
      lidx_q <= lidx_d;
      ptr_q  <= ptr_d;
    end
  end

endmodule

// ----- hw/rtl/psfla_wait_ctr.sv -----
// Saturating wait counter for one ingress port.
// Depends on psfla_pkg.
module psfla_wait_ctr import psfla_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               inc_i,
  output logic [OutCntW-1:0] cnt_o
);

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

  // Count up unless already at the top value.
  always_comb begin
    cnt_d = cnt_q;
    if (inc_i && (cnt_q != '1)) begin
      cnt_d = cnt_q + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  // The counter loads together with the result register, so it serves as
  // the result field directly.
  assign cnt_o = OutCntW'(cnt_q);

endmodule

// ----- hw/rtl/packet_switch_frame_lock_arbiter_top.sv -----
// Top level of the packet switch frame lock arbiter.
// Depends on psfla_pkg, psfla_egress_arb and psfla_wait_ctr.
//
// Usage: each input word is one switch cycle, with valid, last and destination
// for every ingress port. It enters on the in_valid_i / in_ready_o channel.
// Each result word gives the grants, active egresses, lost locks, per-egress
// select and the per-ingress saturating wait counts after that cycle, on the
// out_valid_o / out_ready_i channel.
// Path: a word accepted into the input register passes to the result register
// when that register is free or being taken, and its result word is then
// offered on out_valid_o.
// Throughput: one word per cycle while the receiver takes every result word; the
// arbitration for a word is a single pass of logic from the input register to the
// result register, and the arbiter state updates in that same step.
// Stall: when the receiver holds out_ready_i low, the result word holds and
// the input register keeps one more word; after that in_ready_o goes low.
// Reset: rst_ni clears both valid flags, all frame locks, round-robin
// pointers and wait counters.
module packet_switch_frame_lock_arbiter_top import psfla_pkg::*; #(
  parameter int unsigned NUM_PORTS   = 4,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               ingress_valid_0_i,
  input  logic               ingress_valid_1_i,
  input  logic               ingress_valid_2_i,
  input  logic               ingress_valid_3_i,
  input  logic               ingress_last_0_i,
  input  logic               ingress_last_1_i,
  input  logic               ingress_last_2_i,
  input  logic               ingress_last_3_i,
  input  logic [DestW-1:0]   ingress_dest_0_i,
  input  logic [DestW-1:0]   ingress_dest_1_i,
  input  logic [DestW-1:0]   ingress_dest_2_i,
  input  logic [DestW-1:0]   ingress_dest_3_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         grant_mask_o,
  output logic [3:0]         egress_active_mask_o,
  output logic [3:0]         lock_lost_mask_o,
  output logic [DestW-1:0]   egress_select_0_o,
  output logic [DestW-1:0]   egress_select_1_o,
  output logic [DestW-1:0]   egress_select_2_o,
  output logic [DestW-1:0]   egress_select_3_o,
  output logic [OutCntW-1:0] wait_count_0_o,
  output logic [OutCntW-1:0] wait_count_1_o,
  output logic [OutCntW-1:0] wait_count_2_o,
  output logic [OutCntW-1:0] wait_count_3_o
);

  logic                           s1_vld_q;
  logic [PortsMax-1:0]            vld_q;
  logic [PortsMax-1:0]            lst_q;
  logic [PortsMax-1:0][DestW-1:0] dst_q;
  logic                           out_vld_q;
  logic                           out_free;
  logic                           step;

  logic [PortsMax-1:0][PortsMax-1:0] egr_grant;
  egr_status_t [PortsMax-1:0]        egr_status;
  logic [PortsMax-1:0]               grant_all;
  logic [PortsMax-1:0]               inc;
  logic [PortsMax-1:0][OutCntW-1:0]  cnt;

  logic [3:0]                 grant_q;
  logic [3:0]                 active_q;
  logic [3:0]                 lost_q;
  logic [PortsMax-1:0][DestW-1:0] sel_q;

  // Handshake: the result register frees when empty or taken; the input
  // register takes a word when it is empty or moving on.
  assign out_free    = !out_vld_q || out_ready_i;
  assign step        = s1_vld_q && out_free;
  assign in_ready_o  = !s1_vld_q || out_free;
  assign out_valid_o = out_vld_q;

  // Valid flags of both registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      vld_q <= {ingress_valid_3_i, ingress_valid_2_i, ingress_valid_1_i, ingress_valid_0_i};
      lst_q <= {ingress_last_3_i, ingress_last_2_i, ingress_last_1_i, ingress_last_0_i};
      dst_q <= {ingress_dest_3_i, ingress_dest_2_i, ingress_dest_1_i, ingress_dest_0_i};
    end
  end

  // Egress arbiters; egresses beyond the port count stay idle.
  for (genvar e = 0; e < PortsMax; e++) begin : g_egr
    if (e < NUM_PORTS) begin : g_on
      psfla_egress_arb #(
        .NUM_PORTS (NUM_PORTS),
        .EGRESS_ID (e)
      ) u_arb (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .step_i   (step),
        .vld_i    (vld_q),
        .lst_i    (lst_q),
        .dst_i    (dst_q),
        .grant_o  (egr_grant[e]),
        .status_o (egr_status[e])
      );
    end else begin : g_off
      assign egr_grant[e]  = '0;
      assign egr_status[e] = '0;
    end
  end

  // Merge the grants; an ingress addresses one egress, so at most one grants it.
  always_comb begin
    grant_all = '0;
    for (int e = 0; e < PortsMax; e++) begin
      grant_all = grant_all | egr_grant[e];
    end
  end

  // Wait counters count valid, addressable and ungranted beats.
  for (genvar i = 0; i < PortsMax; i++) begin : g_cnt
    if (i < NUM_PORTS) begin : g_on
      assign inc[i] = vld_q[i] && (32'(dst_q[i]) < NUM_PORTS) && !grant_all[i];
      psfla_wait_ctr #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_ctr (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .step_i (step),
        .inc_i  (inc[i]),
        .cnt_o  (cnt[i])
      );
    end else begin : g_off
      assign inc[i] = 1'b0;
      assign cnt[i] = '0;
    end
  end

  // Result register for the arbitration fields.
  always_ff @(posedge clk_i) begin
    if (step) begin
      grant_q <= grant_all;
      for (int e = 0; e < PortsMax; e++) begin
        active_q[e] <= egr_status[e].active;
        lost_q[e]   <= egr_status[e].lost;
        sel_q[e]    <= egr_status[e].sel;
      end
    end
  end

  assign grant_mask_o         = grant_q;
  assign egress_active_mask_o = active_q;
  assign lock_lost_mask_o     = lost_q;
  assign egress_select_0_o    = sel_q[0];
  assign egress_select_1_o    = sel_q[1];
  assign egress_select_2_o    = sel_q[2];
  assign egress_select_3_o    = sel_q[3];
  assign wait_count_0_o       = cnt[0];
  assign wait_count_1_o       = cnt[1];
  assign wait_count_2_o       = cnt[2];
  assign wait_count_3_o       = cnt[3];

endmodule

// ----- hw/rtl/psfla_checker.sv -----
// Port-level checker for the packet switch frame lock arbiter, with its bind.
// Depends on psfla_pkg and packet_switch_frame_lock_arbiter_top.
module psfla_checker import psfla_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [3:0]         grant_mask_o,
  input logic [3:0]         egress_active_mask_o,
  input logic [DestW-1:0]   egress_select_0_o,
  input logic [DestW-1:0]   egress_select_1_o,
  input logic [DestW-1:0]   egress_select_2_o,
  input logic [DestW-1:0]   egress_select_3_o,
  input logic [OutCntW-1:0] wait_count_0_o
);

  // No result word is offered once reset has been applied at an edge.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result word valid during reset");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(grant_mask_o)
      && $stable(egress_active_mask_o) && $stable(wait_count_0_o))
    else $error("stalled result word changed");

  // Every active egress grants exactly one distinct ingress.
  a_grant_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones(grant_mask_o) == $countones(egress_active_mask_o))
    else $error("grant count differs from active egress count");

  // An idle egress shows select zero.
  a_idle_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (egress_active_mask_o[0] || egress_select_0_o == '0)
      && (egress_active_mask_o[1] || egress_select_1_o == '0)
      && (egress_active_mask_o[2] || egress_select_2_o == '0)
      && (egress_active_mask_o[3] || egress_select_3_o == '0))
    else $error("idle egress with nonzero select");

endmodule

bind packet_switch_frame_lock_arbiter_top psfla_checker u_psfla_checker (.*);
